FILE: hdl/usr_pkg.sv
// Shared types and constants for the ultrasonic ranger with moving average.
// Holds the register map, the configuration struct and the per-beat status struct.
// No dependencies.
package usr_pkg;

    localparam int RAW_W  = 24;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int NUM_SENSORS = 3;

    localparam logic [RAW_W-1:0] RAW_MAX = '1;

    localparam logic [1:0] REG_TRIGGER_TICKS  = 2'd0;
    localparam logic [1:0] REG_TIMER_PRESCALE = 2'd1;
    localparam logic [1:0] REG_DISTANCE_SCALE = 2'd2;

    localparam logic [15:0] TRIGGER_TICKS_RST  = 16'd1000;
    localparam logic [15:0] TIMER_PRESCALE_RST = 16'd1024;
    localparam logic [7:0]  DISTANCE_SCALE_RST = 8'd45;

    typedef struct packed {
        logic [15:0] trigger_ticks;
        logic [15:0] timer_prescale;
        logic [7:0]  distance_scale;
    } cfg_t;

    typedef struct packed {
        logic [2:0] trigger_pins;
        logic       busy;
        logic       done;
        logic [1:0] sensor_id;
    } status_t;

endpackage

FILE: hdl/ultrasonic_ranger_with_average.sv
// Ultrasonic ranger with per-sensor moving average, top level.
// Each result beat is registered through stage 1, stage 2 and stage 3 after its input beat is accepted.
// Throughput: one beat per cycle; the three pipeline stages hold together on output stall.
// Reset (rst_n, asynchronous): sequencer idle, counters zero, sample windows and sums
// cleared at once in flip-flops, registers back to 1000 / 1024 / 45; no clearing pass.
module ultrasonic_ranger_with_average #(
    parameter int WIN_DEPTH   = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [1:0]                 sensor_select,
    input  logic [2:0]                 echo_pins,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 trigger_pins,
    output logic                       busy_res,
    output logic                       done_res,
    output logic [1:0]                 sensor_id,
    output logic [usr_pkg::RAW_W-1:0]  distance_raw,
    output logic [usr_pkg::RAW_W-1:0]  distance_filtered,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [usr_pkg::ADDR_W-1:0] paddr,
    input  logic [usr_pkg::DATA_W-1:0] pwdata,
    output logic [usr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import usr_pkg::*;

    cfg_t                   cfg;
    logic                   advance;
    logic                   valid1;
    status_t                st1;
    logic [COUNT_WIDTH-1:0] count1;
    status_t                st_out;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    usr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    usr_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .action        (action),
        .sensor_select (sensor_select),
        .echo_pins     (echo_pins),
        .cfg           (cfg),
        .valid1        (valid1),
        .st1           (st1),
        .count1        (count1)
    );

    usr_filter #(
        .WIN_DEPTH   (WIN_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_filter (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .valid1         (valid1),
        .st1            (st1),
        .count1         (count1),
        .distance_scale (cfg.distance_scale),
        .out_valid      (out_valid),
        .st_out         (st_out),
        .raw_out        (distance_raw),
        .filt_out       (distance_filtered)
    );

    assign trigger_pins = st_out.trigger_pins;
    assign busy_res     = st_out.busy;
    assign done_res     = st_out.done;
    assign sensor_id    = st_out.sensor_id;

endmodule

FILE: hdl/usr_regs.sv
// APB-style configuration registers of the ultrasonic ranger.
// Depends on usr_pkg for the register map and cfg_t.
module usr_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [usr_pkg::ADDR_W-1:0] paddr,
    input  logic [usr_pkg::DATA_W-1:0] pwdata,
    output logic [usr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output usr_pkg::cfg_t              cfg
);
    import usr_pkg::*;

    logic [15:0] trigger_ticks_reg;
    logic [15:0] timer_prescale_reg;
    logic [7:0]  distance_scale_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg  <= TRIGGER_TICKS_RST;
            timer_prescale_reg <= TIMER_PRESCALE_RST;
            distance_scale_reg <= DISTANCE_SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TRIGGER_TICKS:  trigger_ticks_reg  <= pwdata[15:0];
                REG_TIMER_PRESCALE: timer_prescale_reg <= pwdata[15:0];
                REG_DISTANCE_SCALE: distance_scale_reg <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TRIGGER_TICKS:  prdata = DATA_W'(trigger_ticks_reg);
            REG_TIMER_PRESCALE: prdata = DATA_W'(timer_prescale_reg);
            REG_DISTANCE_SCALE: prdata = DATA_W'(distance_scale_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.trigger_ticks  = trigger_ticks_reg;
    assign cfg.timer_prescale = timer_prescale_reg;
    assign cfg.distance_scale = distance_scale_reg;

endmodule

FILE: hdl/usr_ctrl.sv
// Measurement sequencer: trigger pulse, echo wait and prescaled echo counting.
// Registers one status beat per accepted tick. Depends on usr_pkg.
module usr_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic                   action,
    input  logic [1:0]             sensor_select,
    input  logic [2:0]             echo_pins,
    input  usr_pkg::cfg_t          cfg,
    output logic                   valid1,
    output usr_pkg::status_t       st1,
    output logic [COUNT_WIDTH-1:0] count1
);
    import usr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             active_reg, active_next;
    logic [15:0]            trig_cnt_reg, trig_cnt_next;
    logic [15:0]            pre_cnt_reg, pre_cnt_next;
    logic [COUNT_WIDTH-1:0] echo_cnt_reg, echo_cnt_next;
    logic                   valid1_reg;
    status_t                st1_reg;
    logic [COUNT_WIDTH-1:0] count1_reg;

    logic                   accept;
    logic [15:0]            trig_len;
    logic [15:0]            pre_len;
    logic [16:0]            pre_inc;
    logic                   echo_hi;
    logic                   done;
    status_t                st_next;
    logic [COUNT_WIDTH-1:0] count_out;

    assign accept   = in_valid && advance;
    assign trig_len = (cfg.trigger_ticks == 16'd0) ? 16'd1 : cfg.trigger_ticks;
    assign pre_len  = (cfg.timer_prescale == 16'd0) ? 16'd1 : cfg.timer_prescale;
    assign pre_inc  = {1'b0, pre_cnt_reg} + 17'd1;
    assign echo_hi  = (active_reg != 2'd3) && echo_pins[active_reg];

    always_comb
    begin
        phase_next    = phase_reg;
        active_next   = active_reg;
        trig_cnt_next = trig_cnt_reg;
        pre_cnt_next  = pre_cnt_reg;
        echo_cnt_next = echo_cnt_reg;
        done          = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (action && (32'(sensor_select) < NUM_SENSORS))
                begin
                    active_next   = sensor_select;
                    trig_cnt_next = 16'd1;
                    phase_next    = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                if (trig_cnt_reg >= trig_len)
                    phase_next = PH_WAIT;
                else
                    trig_cnt_next = trig_cnt_reg + 16'd1;
            end
            PH_WAIT:
            begin
                if (echo_hi)
                begin
                    pre_cnt_next  = '0;
                    echo_cnt_next = '0;
                    phase_next    = PH_MEAS;
                end
            end
            PH_MEAS:
            begin
                if (echo_hi)
                begin
                    if (pre_inc >= {1'b0, pre_len})
                    begin
                        pre_cnt_next = '0;
                        if (echo_cnt_reg != '1)
                            echo_cnt_next = echo_cnt_reg + COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        pre_cnt_next = pre_inc[15:0];
                    end
                end
                else
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        st_next.trigger_pins = (phase_next == PH_TRIG) ? (3'b001 << active_next) : 3'b000;
        st_next.busy         = (phase_next != PH_IDLE);
        st_next.done         = done;
        st_next.sensor_id    = done ? active_reg : 2'd0;
        count_out            = done ? echo_cnt_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            active_reg   <= '0;
            trig_cnt_reg <= '0;
            pre_cnt_reg  <= '0;
            echo_cnt_reg <= '0;
            valid1_reg   <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= in_valid;
            if (accept)
            begin
                phase_reg    <= phase_next;
                active_reg   <= active_next;
                trig_cnt_reg <= trig_cnt_next;
                pre_cnt_reg  <= pre_cnt_next;
                echo_cnt_reg <= echo_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st1_reg    <= st_next;
            count1_reg <= count_out;
        end
    end

    assign valid1 = valid1_reg;
    assign st1    = st1_reg;
    assign count1 = count1_reg;

`ifndef SYNTHESIS
    a_trig_exits_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_TRIG) |=> (phase_reg == PH_TRIG || phase_reg == PH_WAIT))
        else $error("trigger phase left to a phase other than echo wait");
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_MEAS && echo_hi) |=> (echo_cnt_reg >= $past(echo_cnt_reg)))
        else $error("echo count decreased during measurement");
    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (phase_reg == PH_IDLE && valid1_reg && !st1_reg.busy))
        else $error("completed measurement did not return to idle");
`endif

endmodule

FILE: hdl/usr_filter.sv
// Distance scaling and per-sensor moving average window.
// Stage 2 scales and updates the window sum, stage 3 divides and holds the result beat.
// Depends on usr_pkg.
module usr_filter #(
    parameter int WIN_DEPTH   = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         valid1,
    input  usr_pkg::status_t             st1,
    input  logic [COUNT_WIDTH-1:0]       count1,
    input  logic [7:0]                   distance_scale,
    output logic                         out_valid,
    output usr_pkg::status_t             st_out,
    output logic [usr_pkg::RAW_W-1:0]    raw_out,
    output logic [usr_pkg::RAW_W-1:0]    filt_out
);
    import usr_pkg::*;

    localparam int SENS_W    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int POS_W     = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int SUM_W     = RAW_W + $clog2(WIN_DEPTH);
    localparam int PROD_W    = COUNT_WIDTH + 8;
    localparam int DIV_SHIFT = SUM_W + $clog2(WIN_DEPTH);
    localparam int MULT_W    = SUM_W + 1;
    localparam int QP_W      = SUM_W + MULT_W;
    localparam logic [63:0] DIV_ONE       = 64'd1 << DIV_SHIFT;
    localparam logic [63:0] DIV_MULT_FULL = (DIV_ONE + 64'(WIN_DEPTH) - 64'd1) / 64'(WIN_DEPTH);
    localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT_FULL[MULT_W-1:0];
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WIN_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

    logic [RAW_W-1:0]  win_reg  [NUM_SENSORS][WIN_DEPTH];
    logic [POS_W-1:0]  pos_reg  [NUM_SENSORS];
    logic [FILL_W-1:0] fill_reg [NUM_SENSORS];
    logic [SUM_W-1:0]  sum_reg  [NUM_SENSORS];

    logic              valid2_reg;
    status_t           st2_reg;
    logic [RAW_W-1:0]  raw2_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic              full2_reg;

    logic              valid3_reg;
    status_t           st3_reg;
    logic [RAW_W-1:0]  raw3_reg;
    logic [RAW_W-1:0]  filt3_reg;

    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  raw;
    logic [SENS_W-1:0] sidx;
    logic [POS_W-1:0]  pos_new;
    logic [RAW_W-1:0]  old_sample;
    logic [SUM_W-1:0]  sum_new;
    logic [FILL_W-1:0] fill_new;
    logic              full;
    logic              win_wr;
    logic [QP_W-1:0]   quot_prod;
    logic [RAW_W-1:0]  quot;

    always_comb
    begin
        prod       = PROD_W'(count1) * PROD_W'(distance_scale);
        raw        = ((prod >> RAW_W) != '0) ? RAW_MAX : RAW_W'(prod);
        sidx       = SENS_W'(st1.sensor_id);
        pos_new    = (pos_reg[sidx] == POS_LAST) ? '0 : pos_reg[sidx] + POS_W'(1);
        old_sample = win_reg[sidx][pos_new];
        sum_new    = sum_reg[sidx] - SUM_W'(old_sample) + SUM_W'(raw);
        fill_new   = (fill_reg[sidx] == FILL_FULL) ? FILL_FULL : fill_reg[sidx] + FILL_W'(1);
        full       = (fill_new == FILL_FULL);
        win_wr     = advance && valid1 && st1.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
                sum_reg[i]  <= '0;
                for (int j = 0; j < WIN_DEPTH; j++)
                    win_reg[i][j] <= '0;
            end
        end
        else if (win_wr)
        begin
            pos_reg[sidx]           <= pos_new;
            fill_reg[sidx]          <= fill_new;
            sum_reg[sidx]           <= sum_new;
            win_reg[sidx][pos_new]  <= raw;
        end
    end

    assign quot_prod = sum2_reg * DIV_MULT;
    assign quot      = quot_prod[DIV_SHIFT +: RAW_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid2_reg <= valid1;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st2_reg   <= st1;
            raw2_reg  <= raw;
            sum2_reg  <= sum_new;
            full2_reg <= st1.done && full;
            st3_reg   <= st2_reg;
            raw3_reg  <= raw2_reg;
            filt3_reg <= full2_reg ? quot : raw2_reg;
        end
    end

    assign out_valid = valid3_reg;
    assign st_out    = st3_reg;
    assign raw_out   = raw3_reg;
    assign filt_out  = filt3_reg;

`ifndef SYNTHESIS
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && valid1 && st1.done) |=> !(valid1 && st1.done))
        else $error("two completed measurements in adjacent beats");
    a_partial_window_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && valid2_reg && !full2_reg) |=> (filt3_reg == raw3_reg))
        else $error("filtered value differs from raw before the window is full");
    a_idle_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid3_reg && !st3_reg.done) |-> (raw3_reg == '0 && filt3_reg == '0))
        else $error("distance reported on a beat without a completed measurement");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for ultrasonic_ranger_with_average: drives tick beats and APB
// register writes and checks every result beat against an in-bench ranging predictor.
// Depends on hdl/usr_pkg.sv and hdl/ultrasonic_ranger_with_average.sv.
`timescale 1ns / 100ps

module tb_top;
    import usr_pkg::*;

    localparam int FILT      = 5;
    localparam int SENSORS   = 3;
    localparam int COUNT_MAX = 65535;
    localparam int LIMIT     = 50000;

    typedef enum logic [3:0] {
        SEQ_IDLE = 4'b0001,
        SEQ_TRIG = 4'b0010,
        SEQ_WAIT = 4'b0100,
        SEQ_MEAS = 4'b1000
    } seq_t;

    typedef struct packed {
        logic       act;
        logic [1:0] sel;
        logic [2:0] echo;
    } tick_beat_t;

    typedef struct packed {
        logic [2:0]       trig;
        logic             busy;
        logic             done;
        logic [1:0]       id;
        logic [RAW_W-1:0] raw;
        logic [RAW_W-1:0] filt;
    } ranging_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              action = 1'b0;
    logic [1:0]        sensor_select = '0;
    logic [2:0]        echo_pins = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        trigger_pins;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        sensor_id;
    logic [RAW_W-1:0]  distance_raw;
    logic [RAW_W-1:0]  distance_filtered;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tick_beat_t ticks_pending[$];
    ranging_t   ranging_due[$];
    tick_beat_t on_bus;
    int         queued_total = 0;
    int         accepted_total = 0;
    int         queued_phase = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         stall_left = 0;
    bit         steady = 1'b0;

    cfg_t                reg_shadow;
    seq_t                seq_state;
    logic [1:0]          meas_sensor;
    logic [15:0]         trig_cnt;
    int unsigned         prescale_cnt;
    longint unsigned     echo_units;
    longint unsigned     samples[SENSORS][FILT];
    int unsigned         slot[SENSORS];
    int unsigned         filled[SENSORS];
    longint unsigned     run_sum[SENSORS];

    ultrasonic_ranger_with_average #(
        .WIN_DEPTH   (FILT),
        .COUNT_WIDTH (16)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .sensor_select     (sensor_select),
        .echo_pins         (echo_pins),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .trigger_pins      (trigger_pins),
        .busy_res          (busy_res),
        .done_res          (done_res),
        .sensor_id         (sensor_id),
        .distance_raw      (distance_raw),
        .distance_filtered (distance_filtered),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 clk = ~clk;

    function automatic ranging_t ranger_tick(tick_beat_t t);
        ranging_t        r;
        int unsigned     trig_len;
        int unsigned     pre_len;
        int unsigned     s;
        int unsigned     pos;
        longint unsigned raw;
        longint unsigned filt;
        bit              echo_hi;
        bit              done;
        r        = '0;
        raw      = 0;
        filt     = 0;
        done     = 1'b0;
        s        = meas_sensor;
        trig_len = (reg_shadow.trigger_ticks == 0) ? 1 : reg_shadow.trigger_ticks;
        pre_len  = (reg_shadow.timer_prescale == 0) ? 1 : reg_shadow.timer_prescale;
        echo_hi  = t.echo[s];
        case (seq_state)
            SEQ_IDLE:
            begin
                if (t.act && t.sel < SENSORS)
                begin
                    meas_sensor = t.sel;
                    s           = t.sel;
                    trig_cnt    = 16'd1;
                    seq_state   = SEQ_TRIG;
                end
            end
            SEQ_TRIG:
            begin
                if (trig_cnt >= trig_len)
                    seq_state = SEQ_WAIT;
                else
                    trig_cnt = trig_cnt + 16'd1;
            end
            SEQ_WAIT:
            begin
                if (echo_hi)
                begin
                    prescale_cnt = 0;
                    echo_units   = 0;
                    seq_state    = SEQ_MEAS;
                end
            end
            default:
            begin
                if (echo_hi)
                begin
                    prescale_cnt++;
                    if (prescale_cnt >= pre_len)
                    begin
                        prescale_cnt = 0;
                        if (echo_units < COUNT_MAX)
                            echo_units++;
                    end
                end
                else
                begin
                    raw = echo_units * reg_shadow.distance_scale;
                    if (raw > RAW_MAX)
                        raw = RAW_MAX;
                    pos             = (slot[s] + 1) % FILT;
                    slot[s]         = pos;
                    run_sum[s]      = run_sum[s] - samples[s][pos] + raw;
                    samples[s][pos] = raw;
                    if (filled[s] < FILT)
                        filled[s]++;
                    filt      = (filled[s] >= FILT) ? run_sum[s] / FILT : raw;
                    done      = 1'b1;
                    seq_state = SEQ_IDLE;
                end
            end
        endcase
        r.trig = (seq_state == SEQ_TRIG) ? 3'(1 << meas_sensor) : 3'd0;
        r.busy = (seq_state != SEQ_IDLE);
        r.done = done;
        r.id   = done ? 2'(s) : 2'd0;
        r.raw  = done ? RAW_W'(raw) : '0;
        r.filt = done ? RAW_W'(filt) : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [RAW_W-1:0] got, logic [RAW_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic logic [2:0] echo_with(logic [1:0] sel, bit level);
        logic [2:0] e;
        e      = 3'($urandom);
        e[sel] = level;
        return e;
    endfunction

    task automatic push_tick(bit act, logic [1:0] sel, logic [2:0] echo);
        tick_beat_t b;
        b.act  = act;
        b.sel  = sel;
        b.echo = echo;
        ticks_pending.push_back(b);
        queued_total++;
        queued_phase++;
    endtask

    // start, trigger and echo wait, echo high for hold ticks, echo fall, idle tail
    task automatic queue_episode(logic [1:0] sel, int lead, int hold, int tail);
        push_tick(1'b1, sel, 3'($urandom));
        repeat (lead)
            push_tick($urandom_range(7) == 0, 2'($urandom), echo_with(sel, 1'b0));
        repeat (hold)
            push_tick($urandom_range(7) == 0, 2'($urandom), echo_with(sel, 1'b1));
        push_tick(1'b0, 2'($urandom), echo_with(sel, 1'b0));
        repeat (tail)
            push_tick(1'b0, 2'($urandom), 3'($urandom));
    endtask

    task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TRIGGER_TICKS:
            begin
                reg_shadow.trigger_ticks = val[15:0];
                want = DATA_W'(val[15:0]);
            end
            REG_TIMER_PRESCALE:
            begin
                reg_shadow.timer_prescale = val[15:0];
                want = DATA_W'(val[15:0]);
            end
            default:
            begin
                reg_shadow.distance_scale = val[7:0];
                want = DATA_W'(val[7:0]);
            end
        endcase
        // read back
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("prdata got %0h want %0h", prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (accepted_total != queued_total || ranging_due.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ranging_due.push_back(ranger_tick(on_bus));
            accepted_total++;
        end
        if (!in_valid || in_ready)
        begin
            if (rst_n && ticks_pending.size() != 0 && (steady || $urandom_range(99) >= 21))
            begin
                on_bus = ticks_pending.pop_front();
                in_valid      <= 1'b1;
                action        <= on_bus.act;
                sensor_select <= on_bus.sel;
                echo_pins     <= on_bus.echo;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        ranging_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (ranging_due.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = ranging_due.pop_front();
                check_field("trigger_pins", RAW_W'(trigger_pins), RAW_W'(want.trig));
                check_field("busy_res", RAW_W'(busy_res), RAW_W'(want.busy));
                check_field("done_res", RAW_W'(done_res), RAW_W'(want.done));
                check_field("sensor_id", RAW_W'(sensor_id), RAW_W'(want.id));
                check_field("distance_raw", distance_raw, want.raw);
                check_field("distance_filtered", distance_filtered, want.filt);
            end
        end
        out_ready <= (stall_left == 0) && (steady || $urandom_range(99) >= 21);
    end

    // hold off the result side long enough to back up the pipeline
    always @(posedge clk)
    begin
        if (cycles == 150)
            stall_left <= 60;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        reg_shadow   = '{trigger_ticks: TRIGGER_TICKS_RST, timer_prescale: TIMER_PRESCALE_RST,
                         distance_scale: DISTANCE_SCALE_RST};
        seq_state    = SEQ_IDLE;
        meas_sensor  = '0;
        trig_cnt     = '0;
        prescale_cnt = 0;
        echo_units   = 0;
        for (int i = 0; i < SENSORS; i++)
        begin
            slot[i]    = 0;
            filled[i]  = 0;
            run_sum[i] = 0;
            for (int j = 0; j < FILT; j++)
                samples[i][j] = 0;
        end
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        reg_write(REG_TRIGGER_TICKS, 1);
        reg_write(REG_TIMER_PRESCALE, 1);
        reg_write(REG_DISTANCE_SCALE, 255);
        push_tick(1'b0, 2'd0, 3'd0);
        push_tick(1'b1, 2'd3, 3'd7);
        push_tick(1'b1, 2'd0, 3'd0);
        push_tick(1'b1, 2'd1, 3'd0);
        push_tick(1'b0, 2'd0, 3'd6);
        push_tick(1'b0, 2'd0, 3'd1);
        push_tick(1'b0, 2'd0, 3'd1);
        push_tick(1'b0, 2'd0, 3'd1);
        push_tick(1'b0, 2'd0, 3'd6);
        push_tick(1'b1, 2'd2, 3'd0);
        push_tick(1'b0, 2'd0, 3'd3);
        push_tick(1'b0, 2'd0, 3'd4);
        push_tick(1'b0, 2'd0, 3'd3);
        push_tick(1'b1, 2'd1, 3'd7);
        push_tick(1'b0, 2'd0, 3'd0);
        push_tick(1'b0, 2'd0, 3'd2);
        push_tick(1'b0, 2'd0, 3'd2);
        push_tick(1'b0, 2'd0, 3'd5);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            reg_write(REG_TRIGGER_TICKS, $urandom_range(1, 4));
            reg_write(REG_TIMER_PRESCALE, $urandom_range(1, 3));
            reg_write(REG_DISTANCE_SCALE, (p == 0) ? 0 : (p == 1) ? 1 : $urandom_range(2, 254));
            steady       = (p == 1);
            queued_phase = 0;
            while (queued_phase < 217)
            begin
                if ($urandom_range(99) < 80)
                    queue_episode(2'($urandom_range(0, 2)),
                                  reg_shadow.trigger_ticks + 1 + $urandom_range(0, 3),
                                  $urandom_range(1, 12), $urandom_range(0, 3));
                else
                    repeat ($urandom_range(1, 6))
                        push_tick(1'($urandom), 2'($urandom), 3'($urandom));
            end
            drain();
        end
        steady = 1'b0;

        // zero registers act as one
        reg_write(REG_TRIGGER_TICKS, 0);
        reg_write(REG_TIMER_PRESCALE, 0);
        reg_write(REG_DISTANCE_SCALE, 255);
        queue_episode(2'd2, 3, 20, 2);
        drain();
        repeat (8)
            @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
